// ----- hw/rtl/tpa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package tpa_pkg;

  localparam int KIND_W   = 3;
  localparam int RKIND_W  = 2;
  localparam int LEN_W    = 16;
  localparam int ANG_W    = 16;
  localparam int IN_W     = 24;
  localparam int AREA_W   = 56;
  localparam int CROSS_W  = 64;
  localparam int CZ_W     = 34;
  localparam int CX_W     = 48;
  localparam int ATAN_N   = 24;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int COORD_BITS_DEF   = 24;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic [47:0] GAIN_Q32 = 48'd2608131496;

  localparam logic [KIND_W-1:0] K_STEP    = 3'd0;
  localparam logic [KIND_W-1:0] K_OPEN    = 3'd1;
  localparam logic [KIND_W-1:0] K_CLOSE   = 3'd2;
  localparam logic [KIND_W-1:0] K_SETPOS  = 3'd3;
  localparam logic [KIND_W-1:0] K_SETHEAD = 3'd4;
  localparam logic [KIND_W-1:0] K_RESTART = 3'd5;

  localparam logic [RKIND_W-1:0] R_POS   = 2'd0;
  localparam logic [RKIND_W-1:0] R_POLY  = 2'd1;
  localparam logic [RKIND_W-1:0] R_NOPEN = 2'd2;

  // datapath commands
  typedef enum logic [3:0] {
    C_NONE, C_LOAD, C_HEAD, C_CINIT, C_CITER, C_CDONE, C_MOVE,
    C_XTERM, C_XACC, C_AREA, C_DINIT, C_DITER, C_DDONE, C_OTHER
  } cmd_t;

  typedef struct packed {
    logic is_step;
    logic poly_open;
    logic is_close;
  } tpa_status_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    begin
      unique case (i)
        5'd0:  r = 32'd536870912; 5'd1:  r = 32'd316933406;
        5'd2:  r = 32'd167458907; 5'd3:  r = 32'd85004756;
        5'd4:  r = 32'd42667331;  5'd5:  r = 32'd21354465;
        5'd6:  r = 32'd10680862;  5'd7:  r = 32'd5340245;
        5'd8:  r = 32'd2670163;   5'd9:  r = 32'd1335087;
        5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
        5'd20: r = 32'd652;       5'd21: r = 32'd326;
        5'd22: r = 32'd163;       default: r = 32'd81;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/tpa_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tpa_ctrl #(
  parameter int CORDIC_STEPS = 16,
  parameter int DIV_STEPS    = 36
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_beat,
  input  wire logic           out_free,
  input  wire tpa_pkg::tpa_status_t st,
  output tpa_pkg::cmd_t       cmd,
  output logic                busy,
  output logic                res_load
);
  import tpa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_CINIT, S_CITER, S_CDONE, S_MOVE, S_XT, S_XA,
    S_AREA, S_DINIT, S_DITER, S_DDONE, S_OTHER, S_EMIT
  } state_t;

  localparam int CNT_W = $clog2(DIV_STEPS + CORDIC_STEPS + 1);

  state_t state;
  logic [CNT_W-1:0] cnt;

  // command decode
  always_comb begin
    unique case (state)
      S_DEC:   cmd = C_HEAD;
      S_CINIT: cmd = C_CINIT;
      S_CITER: cmd = C_CITER;
      S_CDONE: cmd = C_CDONE;
      S_MOVE:  cmd = C_MOVE;
      S_XT:    cmd = C_XTERM;
      S_XA:    cmd = C_XACC;
      S_AREA:  cmd = C_AREA;
      S_DINIT: cmd = C_DINIT;
      S_DITER: cmd = C_DITER;
      S_DDONE: cmd = C_DDONE;
      S_OTHER: cmd = C_OTHER;
      default: cmd = in_beat ? C_LOAD : C_NONE;
    endcase
  end

  assign busy     = (state != S_IDLE);
  assign res_load = (state == S_EMIT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE:  if (in_beat) state <= S_DEC;
        S_DEC:   state <= st.is_step ? S_CINIT :
                          ((st.is_close && st.poly_open) ? S_XT : S_OTHER);
        S_CINIT: begin
          cnt   <= '0;
          state <= S_CITER;
        end
        S_CITER: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(CORDIC_STEPS - 1)) state <= S_CDONE;
        end
        S_CDONE: state <= S_MOVE;
        S_MOVE:  state <= st.poly_open ? S_XT : S_EMIT;
        S_XT:    state <= S_XA;
        S_XA:    state <= st.is_step ? S_EMIT : S_AREA;
        S_AREA:  state <= S_DINIT;
        S_DINIT: begin
          cnt   <= '0;
          state <= S_DITER;
        end
        S_DITER: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DIV_STEPS - 1)) state <= S_DDONE;
        end
        S_DDONE: state <= S_EMIT;
        S_OTHER: state <= S_EMIT;
        S_EMIT:  if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/tpa_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tpa_datapath #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_BITS   = 24,
  parameter int CNT_BITS     = 11,
  parameter int SUM_BITS     = 35
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire tpa_pkg::cmd_t            cmd,
  input  wire logic [2:0]               kind,
  input  wire logic [15:0]              length,
  input  wire logic signed [15:0]       angle,
  input  wire logic signed [23:0]       x_value,
  input  wire logic signed [23:0]       y_value,
  output tpa_pkg::tpa_status_t          st,
  output logic [1:0]                    r_kind,
  output logic signed [23:0]            r_x,
  output logic signed [23:0]            r_y,
  output logic [15:0]                   r_head,
  output logic [55:0]                   r_area,
  output logic signed [23:0]            r_lx,
  output logic signed [23:0]            r_ly,
  output logic signed [23:0]            r_hx,
  output logic signed [23:0]            r_hy,
  output logic                          r_sat
);
  import tpa_pkg::*;

  localparam int CW = COORD_BITS;
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [63:0] I64MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] I64MIN = {1'b1, {63{1'b0}}};
  localparam int QW = SUM_BITS;

  // latched command
  logic [2:0] k;
  logic [15:0] len_r, ang_r;
  logic signed [23:0] xv, yv;

  // architectural state
  logic signed [CW-1:0] cx, cy, lvx, lvy, fvx, fvy, lox, loy, hix, hiy;
  logic [15:0] hd;
  logic signed [63:0] csum;
  logic signed [QW-1:0] sx, sy;
  logic [CNT_BITS-1:0] vc;
  logic popen, sat;

  // cordic
  logic signed [CX_W-1:0] ox, oy;
  logic signed [CZ_W-1:0] oz;
  logic flip;
  logic [4:0] it;
  logic signed [CW+1:0] dxs, dys;

  // cross products
  logic signed [63:0] pp, qq;
  logic [55:0] area_r;
  logic [1:0] rk;

  // divider (restoring, two lanes)
  logic [QW-1:0] mx, my, qx, qy;
  logic [CNT_BITS:0] remx, remy;
  logic negx, negy;
  logic signed [23:0] avgx, avgy;

  // pair for cross term: (last) x (new) or (last) x (first)
  logic signed [CW-1:0] bx, by;
  assign bx = (k == K_STEP) ? cx : fvx;
  assign by = (k == K_STEP) ? cy : fvy;

  assign st.is_step   = (k == K_STEP);
  assign st.poly_open = popen;
  assign st.is_close  = (k == K_CLOSE);

  // combinational helpers
  logic signed [15:0] hs;
  logic signed [16:0] a17;
  logic fl;
  logic signed [CX_W-1:0] tx, ty, fx, fy;
  logic signed [CX_W-1:0] nx, ny;
  logic signed [CW+1:0] mvx, mvy;
  logic signed [64:0] cterm, nsum;
  logic signed [63:0] ct64;
  logic [63:0] mag;
  logic [64:0] ar;
  logic [CNT_BITS:0] trx, try_;
  logic [QW-1:0] hv;

  always_comb begin
    hs  = signed'(hd);
    a17 = 17'(hs);
    fl  = 1'b0;
    if (hs > 16'sd16384) begin a17 = 17'(hs) - 17'sd32768; fl = 1'b1; end
    else if (hs < -16'sd16384) begin a17 = 17'(hs) + 17'sd32768; fl = 1'b1; end
    tx = ox >>> it;
    ty = oy >>> it;
    fx = (flip ? -ox : ox) + CX_W'(32768);
    fy = (flip ? -oy : oy) + CX_W'(32768);
    mvx = (CW+2)'(cx) + dxs;
    mvy = (CW+2)'(cy) + dys;
    // cross term with saturation
    if (qq == I64MIN) cterm = (pp >= 0) ? 65'(I64MAX) : 65'(pp) + 65'(I64MAX);
    else cterm = 65'(pp) - 65'(qq);
    ct64 = (cterm > 65'(I64MAX)) ? I64MAX : 64'(cterm);
    nsum = 65'(csum) + 65'(ct64);
    mag  = csum[63] ? 64'(-csum) : 64'(csum);
    ar   = 65'(mag >> 1) + 65'(mag[0]);
    trx  = {remx[CNT_BITS-1:0], mx[QW-1]} - (CNT_BITS+1)'(vc);
    try_ = {remy[CNT_BITS-1:0], my[QW-1]} - (CNT_BITS+1)'(vc);
    hv   = QW'(vc >> 1);
    nx = ox; ny = oy;
    if (!oz[CZ_W-1]) begin nx = ox - ty; ny = oy + tx; end
    else begin nx = ox + ty; ny = oy - tx; end
  end

  function automatic logic signed [CW-1:0] satc(input logic signed [CW+1:0] v,
                                                 output logic f);
    begin
      f = 1'b1;
      if (v > (CW+2)'(CMAX)) return CMAX;
      if (v < (CW+2)'(CMIN)) return CMIN;
      f = 1'b0;
      return CW'(v);
    end
  endfunction

  logic sfx, sfy, sfvx, sfvy;
  logic signed [CW-1:0] nmx, nmy, svx, svy;
  always_comb begin
    nmx = satc(mvx, sfx);
    nmy = satc(mvy, sfy);
    svx = satc((CW+2)'(xv), sfvx);
    svy = satc((CW+2)'(yv), sfvy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cx <= '0; cy <= '0; hd <= '0; lvx <= '0; lvy <= '0; fvx <= '0; fvy <= '0;
      csum <= '0; sx <= '0; sy <= '0; vc <= '0; popen <= 1'b0; sat <= 1'b0;
      lox <= CMAX; loy <= CMAX; hix <= CMIN; hiy <= CMIN;
    end else begin
      unique case (cmd)
        C_LOAD: begin
          k <= kind; len_r <= length; ang_r <= angle; xv <= x_value; yv <= y_value;
          rk <= R_POS;
        end
        C_HEAD: begin
          if (k == K_STEP) hd <= hd + ang_r;
          if (k == K_CLOSE && !popen) rk <= R_NOPEN;
        end
        C_CINIT: begin
          flip <= fl;
          oz   <= CZ_W'(a17) <<< 16;
          ox   <= CX_W'((48'(len_r) * GAIN_Q32) >> 16);
          oy   <= '0;
          it   <= '0;
        end
        C_CITER: begin
          ox <= nx; oy <= ny;
          oz <= oz[CZ_W-1] ? oz + CZ_W'(atan_lut(it)) : oz - CZ_W'(atan_lut(it));
          if (it < 5'(ATAN_N - 1)) it <= it + 1'b1;
        end
        C_CDONE: begin
          dxs <= (CW+2)'(fx >>> 16);
          dys <= (CW+2)'(fy >>> 16);
        end
        C_MOVE: begin
          cx <= nmx; cy <= nmy;
          // with a polygon open the last vertex moves after its cross term
          if (!popen) begin lvx <= nmx; lvy <= nmy; end
          if (sfx || sfy) sat <= 1'b1;
          if (nmx < lox) lox <= nmx;
          if (nmy < loy) loy <= nmy;
          if (nmx > hix) hix <= nmx;
          if (nmy > hiy) hiy <= nmy;
          if (popen) begin
            if (vc < CNT_BITS'(MAX_VERTICES)) begin
              sx <= sx + QW'(nmx); sy <= sy + QW'(nmy); vc <= vc + 1'b1;
            end else sat <= 1'b1;
          end
        end
        C_XTERM: begin
          pp <= 64'(lvx) * 64'(by);
          qq <= 64'(bx) * 64'(lvy);
          if (k == K_STEP) begin lvx <= cx; lvy <= cy; end
        end
        C_XACC: begin
          if (qq == I64MIN || cterm > 65'(I64MAX)) sat <= 1'b1;
          if (nsum > 65'(I64MAX)) begin csum <= I64MAX; sat <= 1'b1; end
          else if (nsum < 65'(I64MIN)) begin csum <= I64MIN; sat <= 1'b1; end
          else csum <= 64'(nsum);
        end
        C_AREA: begin
          if (ar > 65'({56{1'b1}})) begin area_r <= '1; sat <= 1'b1; end
          else area_r <= 56'(ar);
          popen <= 1'b0;
          rk <= R_POLY;
        end
        C_DINIT: begin
          negx <= sx[QW-1]; negy <= sy[QW-1];
          mx <= (sx[QW-1] ? QW'(-sx) : QW'(sx)) + hv;
          my <= (sy[QW-1] ? QW'(-sy) : QW'(sy)) + hv;
          remx <= '0; remy <= '0; qx <= '0; qy <= '0;
        end
        C_DITER: begin
          mx <= mx << 1; my <= my << 1;
          if (!trx[CNT_BITS]) begin remx <= trx; qx <= {qx[QW-2:0], 1'b1}; end
          else begin remx <= {remx[CNT_BITS-1:0], mx[QW-1]}; qx <= {qx[QW-2:0], 1'b0}; end
          if (!try_[CNT_BITS]) begin remy <= try_; qy <= {qy[QW-2:0], 1'b1}; end
          else begin remy <= {remy[CNT_BITS-1:0], my[QW-1]}; qy <= {qy[QW-2:0], 1'b0}; end
        end
        C_DDONE: begin
          avgx <= 24'(negx ? -qx : qx);
          avgy <= 24'(negy ? -qy : qy);
        end
        C_OTHER: begin
          unique case (k)
            K_OPEN: begin
              popen <= 1'b1; fvx <= lvx; fvy <= lvy; csum <= '0;
              sx <= QW'(lvx); sy <= QW'(lvy); vc <= CNT_BITS'(1);
            end
            K_SETPOS: begin
              cx <= svx; cy <= svy;
              if (sfvx || sfvy) sat <= 1'b1;
            end
            K_SETHEAD: hd <= ang_r;
            K_RESTART: begin
              cx <= '0; cy <= '0; hd <= '0; lvx <= '0; lvy <= '0; popen <= 1'b0;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // result fields; position holds the vertex average in a polygon report
  always_comb begin
    r_kind = rk;
    r_head = hd;
    r_area = (rk == R_POLY) ? area_r : '0;
    r_x = (rk == R_POLY) ? avgx : 24'(cx);
    r_y = (rk == R_POLY) ? avgy : 24'(cy);
    r_lx = 24'(lox); r_ly = 24'(loy); r_hx = 24'(hix); r_hy = 24'(hiy);
    r_sat = sat;
  end
endmodule
`default_nettype wire

// ----- hw/rtl/turtle_path_polygon_area_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | handshake             | tdata / tuser
// s_axis  | in  | s_tvalid / s_tready   | length, angle, x_value, y_value / kind
// m_axis  | out | m_tvalid / m_tready   | pos_x..area..saturated / result_kind
// One command at a time: a step runs the CORDIC iterations and the move,
// plus the cross term with a polygon open; a close of an open polygon adds
// the area and averages (two-lane restoring divider, one bit a cycle). Reset
// is synchronous and clears position, heading, polygon, bounding box and flags.
// The result register holds while m_tready is low; the next command is
// taken once the result has moved into the output register.
module turtle_path_polygon_area_top #(
  parameter int MAX_VERTICES = tpa_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = tpa_pkg::COORD_BITS_DEF,
  parameter int CORDIC_STEPS = tpa_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // length[15:0], angle[31:16], x_value[55:32], y_value[79:56]
  input  wire logic [79:0]  s_tdata,
  // kind[2:0]
  input  wire logic [2:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // pos_x[23:0] pos_y[47:24] heading[63:48] area[119:64] min_x[143:120]
  // min_y[167:144] max_x[191:168] max_y[215:192] saturated[216]
  output logic [223:0]      m_tdata,
  // result_kind[1:0]
  output logic [1:0]        m_tuser
);
  import tpa_pkg::*;

  localparam int CNT_BITS = $clog2(MAX_VERTICES + 1);
  localparam int SUM_BITS = COORD_BITS + CNT_BITS;

  cmd_t cmd;
  tpa_status_t st;
  logic busy, res_load, in_beat, out_free;
  logic [1:0] rk;
  logic signed [23:0] rx, ry, lx, ly, hx, hy;
  logic [15:0] rh;
  logic [55:0] ra;
  logic rs;

  assign s_tready = !busy;
  assign in_beat  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  tpa_ctrl #(.CORDIC_STEPS(CORDIC_STEPS), .DIV_STEPS(SUM_BITS)) u_ctrl (
    .clk, .rst, .in_beat, .out_free, .st, .cmd, .busy, .res_load
  );

  tpa_datapath #(
    .MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS),
    .CNT_BITS(CNT_BITS), .SUM_BITS(SUM_BITS)
  ) u_dp (
    .clk, .rst, .cmd, .kind(s_tuser), .length(s_tdata[15:0]),
    .angle(s_tdata[31:16]), .x_value(s_tdata[55:32]), .y_value(s_tdata[79:56]),
    .st, .r_kind(rk), .r_x(rx), .r_y(ry), .r_head(rh), .r_area(ra),
    .r_lx(lx), .r_ly(ly), .r_hx(hx), .r_hy(hy), .r_sat(rs)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (res_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (res_load) begin
      m_tdata <= {7'd0, rs, hy, hx, ly, lx, ra, rh, ry, rx};
      m_tuser <= rk;
    end
  end

  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> !s_tready) else $error("accepted while busy");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!m_tvalid || m_tready)) else $error("result overwritten");
  a_kind_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == R_POS || m_tuser == R_POLY || m_tuser == R_NOPEN))
    else $error("bad result kind");
endmodule
`default_nettype wire
